[rtl/deleted_id_compaction_remap_assert.svh]
// ----------------------------------------------------------------------------
// Deleted ID compaction remapper: assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DELETED_ID_COMPACTION_REMAP_ASSERT_SVH
`define DELETED_ID_COMPACTION_REMAP_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define DICR_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define DICR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dicr_pkg.sv]
// ----------------------------------------------------------------------------
// Deleted ID compaction remapper: package
// Operation, status and control state types shared by the design.
// ----------------------------------------------------------------------------
package dicr_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR     = 2'd0,
    OP_APPEND    = 2'd1,
    OP_TRANSLATE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ORDER = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_WAIT
  } state_t;

endpackage

[rtl/dicr_ram.sv]
// ----------------------------------------------------------------------------
// Deleted ID compaction remapper: generic RAM
// Single write port and single read port, read data registered.
// ----------------------------------------------------------------------------
module dicr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/deleted_id_compaction_remap.sv]
// ----------------------------------------------------------------------------
// Deleted ID compaction remapper
// Holds a sorted table of deleted IDs and maps a node ID to its compacted ID,
// the node ID less the number of table entries strictly below it, floored at zero.
// ----------------------------------------------------------------------------
// Clear, append and unused operation words finish without a search, as does a
// translate on an empty table or with an ID below the first or above the last
// entry; first and last entries are kept in registers for these checks. Any
// other translate runs a lower-bound binary search through the ID memory, one
// read per cycle on its single read port. One word is worked on at a time; a
// new word is taken as soon as the previous result has moved into the output
// register, even while that result is stalled.
`include "deleted_id_compaction_remap_assert.svh"

module deleted_id_compaction_remap #(
  parameter int MAX_DELETED = 1024,
  parameter int ID_WIDTH    = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_operation,
  input  logic [ID_WIDTH-1:0]                  in_node_id,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ID_WIDTH-1:0]                  out_new_id,
  output logic [1:0]                           out_status,
  output logic [$clog2(MAX_DELETED+1)-1:0]     out_entries_in_use
);

  localparam int AW = $clog2(MAX_DELETED);
  localparam int CW = $clog2(MAX_DELETED + 1);
  localparam int WW = (ID_WIDTH > CW) ? ID_WIDTH : CW;

  dicr_pkg::state_t   state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [ID_WIDTH-1:0] first_r, first_nxt;
  logic [ID_WIDTH-1:0] last_r, last_nxt;
  logic [ID_WIDTH-1:0] id_r, id_nxt;
  logic [CW-1:0]      lo_r, lo_nxt;
  logic [CW-1:0]      hi_r, hi_nxt;
  logic [CW-1:0]      mid_r, mid_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [ID_WIDTH-1:0] out_new_id_r, out_new_id_nxt;
  dicr_pkg::status_t  out_status_r, out_status_nxt;
  logic [CW-1:0]      out_cnt_r, out_cnt_nxt;

  logic [ID_WIDTH-1:0] res_new_id_r, res_new_id_nxt;
  dicr_pkg::status_t  res_status_r, res_status_nxt;

  logic               accept;
  logic               out_free;
  logic               done;
  logic [ID_WIDTH-1:0] done_new_id;
  dicr_pkg::status_t  done_status;

  logic               sat_en;
  logic [ID_WIDTH-1:0] sat_id;
  logic [CW-1:0]      sat_shift;
  logic [WW-1:0]      sat_diff;
  logic [ID_WIDTH-1:0] sat_res;

  logic [CW-1:0]      lo_step, hi_step;

  logic               wr_en;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [ID_WIDTH-1:0] rd_data;

  dicr_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (MAX_DELETED)
  ) u_ids (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_node_id),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall = (state_r != dicr_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign sat_diff = WW'(sat_id) - WW'(sat_shift);
  assign sat_res  = (WW'(sat_shift) > WW'(sat_id)) ? '0 : sat_diff[ID_WIDTH-1:0];

  always_comb begin
    lo_step = lo_r;
    hi_step = hi_r;
    if (rd_data < id_r) begin
      lo_step = mid_r + CW'(1);
    end else begin
      hi_step = mid_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    id_nxt         = id_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    res_new_id_nxt = res_new_id_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_new_id_nxt = out_new_id_r;
    out_status_nxt = out_status_r;
    out_cnt_nxt    = out_cnt_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = mid_r[AW-1:0];
    done           = 1'b0;
    done_new_id    = '0;
    done_status    = dicr_pkg::ST_OK;
    sat_en         = 1'b0;
    sat_id         = in_node_id;
    sat_shift      = count_r;

    unique case (state_r)
      dicr_pkg::S_IDLE: begin
        if (accept) begin
          unique case (dicr_pkg::op_t'(in_operation))
            dicr_pkg::OP_CLEAR: begin
              count_nxt = '0;
              done      = 1'b1;
            end
            dicr_pkg::OP_APPEND: begin
              done = 1'b1;
              if (count_r >= CW'(MAX_DELETED)) begin
                done_status = dicr_pkg::ST_FULL;
              end else if ((count_r != '0) && (in_node_id < last_r)) begin
                done_status = dicr_pkg::ST_ORDER;
              end else begin
                wr_en     = 1'b1;
                last_nxt  = in_node_id;
                count_nxt = count_r + CW'(1);
                if (count_r == '0) begin
                  first_nxt = in_node_id;
                end
              end
            end
            dicr_pkg::OP_TRANSLATE: begin
              if ((count_r == '0) || (in_node_id < first_r)) begin
                done        = 1'b1;
                done_new_id = in_node_id;
              end else if (in_node_id > last_r) begin
                done      = 1'b1;
                sat_en    = 1'b1;
                sat_shift = count_r;
              end else begin
                id_nxt    = in_node_id;
                lo_nxt    = '0;
                hi_nxt    = count_r;
                mid_nxt   = count_r >> 1;
                rd_en     = 1'b1;
                rd_addr   = mid_nxt[AW-1:0];
                state_nxt = dicr_pkg::S_SEARCH;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      dicr_pkg::S_SEARCH: begin
        lo_nxt  = lo_step;
        hi_nxt  = hi_step;
        mid_nxt = lo_step + ((hi_step - lo_step) >> 1);
        if (lo_step < hi_step) begin
          rd_en   = 1'b1;
          rd_addr = mid_nxt[AW-1:0];
        end else begin
          done      = 1'b1;
          sat_en    = 1'b1;
          sat_id    = id_r;
          sat_shift = lo_step;
        end
      end
      dicr_pkg::S_WAIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_new_id_nxt = res_new_id_r;
          out_status_nxt = res_status_r;
          out_cnt_nxt    = count_r;
          state_nxt      = dicr_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dicr_pkg::S_IDLE;
      end
    endcase

    if (sat_en) begin
      done_new_id = sat_res;
    end

    if (done) begin
      if (out_free) begin
        out_valid_nxt  = 1'b1;
        out_new_id_nxt = done_new_id;
        out_status_nxt = done_status;
        out_cnt_nxt    = count_nxt;
        state_nxt      = dicr_pkg::S_IDLE;
      end else begin
        res_new_id_nxt = done_new_id;
        res_status_nxt = done_status;
        state_nxt      = dicr_pkg::S_WAIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dicr_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r      <= first_nxt;
    last_r       <= last_nxt;
    id_r         <= id_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    res_new_id_r <= res_new_id_nxt;
    res_status_r <= res_status_nxt;
    out_new_id_r <= out_new_id_nxt;
    out_status_r <= out_status_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_new_id         = out_new_id_r;
  assign out_status         = out_status_r;
  assign out_entries_in_use = out_cnt_r;

  `DICR_ASSERT_NOW(a_count_bound, count_r <= CW'(MAX_DELETED),
    "Entry count exceeds table depth.")
  `DICR_ASSERT_NOW(a_search_window,
    (state_r != dicr_pkg::S_SEARCH) || ((lo_r < hi_r) && (hi_r <= count_r)),
    "Search window is empty or runs past the held entries.")
  `DICR_ASSERT_NOW(a_wait_busy, (state_r != dicr_pkg::S_WAIT) || out_valid_r,
    "Result held back although the output register is empty.")
  `DICR_ASSERT_NEXT(a_count_hold, !(in_valid && !in_stall), $stable(count_r),
    "Entry count changed without an accepted word.")

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deleted ID compaction remapper: self-checking testbench
// Drives clear, append and translate words through the valid/stall input
// channel and checks every result word against a scoreboard that keeps its own
// copy of the deleted ID table. A short directed run covers the special cases,
// then random sequences build small tables, fill the table to its limit and
// probe IDs around the held entries, with random idling and stalls on both
// sides and one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          MAX_IDS     = 1024;
  localparam int          HOLD_CYCLES = 400;
  localparam int          LIMIT       = 300000;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;

  typedef struct packed {
    logic [31:0] new_id;
    logic [1:0]  status;
    logic [10:0] used;
  } remap_word_t;

  class remap_scoreboard;
    logic [31:0] deleted_ids [MAX_IDS];
    int unsigned deleted_count;
    remap_word_t expected_q [$];
    int unsigned mismatches;

    function new();
      deleted_count = 0;
      mismatches    = 0;
    endfunction

    function logic [31:0] compact(logic [31:0] id);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      logic [31:0] shift;
      if (deleted_count == 0) return id;
      if (id > deleted_ids[deleted_count-1]) begin
        shift = 32'(deleted_count);
      end else if (id < deleted_ids[0]) begin
        return id;
      end else begin
        lo = 0;
        hi = deleted_count;
        while (lo < hi) begin
          mid = lo + ((hi - lo) >> 1);
          if (deleted_ids[mid] < id) lo = mid + 1;
          else hi = mid;
        end
        shift = 32'(lo);
      end
      return (shift > id) ? 32'd0 : id - shift;
    endfunction

    function void note_input(logic [1:0] op, logic [31:0] id);
      remap_word_t w;
      w = '0;
      case (op)
        dicr_pkg::OP_CLEAR: deleted_count = 0;
        dicr_pkg::OP_APPEND: begin
          if (deleted_count >= MAX_IDS) begin
            w.status = dicr_pkg::ST_FULL;
          end else if (deleted_count > 0 && id < deleted_ids[deleted_count-1]) begin
            w.status = dicr_pkg::ST_ORDER;
          end else begin
            deleted_ids[deleted_count] = id;
            deleted_count++;
          end
        end
        dicr_pkg::OP_TRANSLATE: w.new_id = compact(id);
        default: ;
      endcase
      w.used = 11'(deleted_count);
      expected_q.push_back(w);
    endfunction

    function void check_result(remap_word_t got);
      remap_word_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result word with none expected: new_id=%h status=%0d used=%0d",
                   got.new_id, got.status, got.used);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected new_id=%h status=%0d used=%0d,",
                   want.new_id, want.status, want.used,
                   " got new_id=%h status=%0d used=%0d",
                   got.new_id, got.status, got.used);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_operation;
  logic [31:0] in_node_id;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_new_id;
  logic [1:0]  out_status;
  logic [10:0] out_entries_in_use;

  bit          steady;
  bit          hold_req;
  int unsigned cycles = 0;

  remap_scoreboard sb = new;

  deleted_id_compaction_remap #(
    .MAX_DELETED(MAX_IDS),
    .ID_WIDTH(32)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_node_id(in_node_id),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_new_id(out_new_id),
    .out_status(out_status),
    .out_entries_in_use(out_entries_in_use)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(remap_word_t'{out_new_id, out_status, out_entries_in_use});
  end

  initial begin
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !steady && ($urandom_range(0, 99) < 11);
    end
  end

  task automatic send_word(logic [1:0] op, logic [31:0] id);
    if (!steady && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_node_id   <= id;
    do @(posedge clk); while (in_stall);
    sb.note_input(op, id);
  endtask

  function automatic logic [31:0] probe_id();
    int unsigned k;
    if (sb.deleted_count == 0) return $urandom;
    k = $urandom_range(0, sb.deleted_count - 1);
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return sb.deleted_ids[0] - 32'd1;
      2: return sb.deleted_ids[sb.deleted_count-1] + 32'd1;
      3: return sb.deleted_ids[k] - 32'd1;
      4: return sb.deleted_ids[k] + 32'd1;
      default: return sb.deleted_ids[k];
    endcase
  endfunction

  function automatic logic [31:0] next_append(logic [31:0] last, int unsigned span);
    logic [32:0] nxt;
    if ($urandom_range(0, 4) == 0) return last;
    nxt = {1'b0, last} + 33'($urandom_range(1, span));
    return nxt[32] ? 32'hFFFF_FFFF : nxt[31:0];
  endfunction

  task automatic small_round();
    int unsigned n;
    int unsigned span;
    logic [31:0] last;
    if ($urandom_range(0, 3) != 0) send_word(dicr_pkg::OP_CLEAR, $urandom);
    if (sb.deleted_count != 0) last = sb.deleted_ids[sb.deleted_count-1];
    else if ($urandom_range(0, 3) == 0) last = 32'd0;
    else last = $urandom;
    case ($urandom_range(0, 3))
      0: span = 1;
      1: span = 64;
      2: span = 1 << 20;
      default: span = 1 << 28;
    endcase
    n = $urandom_range(0, 12);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0 && last != 0) begin
        send_word(dicr_pkg::OP_APPEND, $urandom_range(0, last - 1));
      end else begin
        last = next_append(last, span);
        send_word(dicr_pkg::OP_APPEND, last);
      end
    end
    n = $urandom_range(3, 10);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_word(OP_UNUSED, $urandom);
      else send_word(dicr_pkg::OP_TRANSLATE, probe_id());
    end
  endtask

  initial begin
    logic [31:0] last;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= dicr_pkg::OP_CLEAR;
    in_node_id   <= '0;
    steady   = 1'b0;
    hold_req = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_word(dicr_pkg::OP_TRANSLATE, 32'd0);
    send_word(dicr_pkg::OP_TRANSLATE, 32'hFFFF_FFFF);
    send_word(OP_UNUSED, 32'hFFFF_FFFF);
    send_word(dicr_pkg::OP_APPEND, 32'd100);
    send_word(dicr_pkg::OP_APPEND, 32'd100);
    send_word(dicr_pkg::OP_APPEND, 32'd99);
    send_word(dicr_pkg::OP_APPEND, 32'd300);
    send_word(dicr_pkg::OP_TRANSLATE, 32'd50);
    send_word(dicr_pkg::OP_TRANSLATE, 32'd100);
    send_word(dicr_pkg::OP_TRANSLATE, 32'd101);
    send_word(dicr_pkg::OP_TRANSLATE, 32'd300);
    send_word(dicr_pkg::OP_TRANSLATE, 32'd301);
    send_word(dicr_pkg::OP_TRANSLATE, 32'hFFFF_FFFF);
    send_word(dicr_pkg::OP_APPEND, 32'hFFFF_FFFF);
    send_word(dicr_pkg::OP_TRANSLATE, 32'hFFFF_FFFF);
    send_word(OP_UNUSED, 32'd0);
    send_word(dicr_pkg::OP_CLEAR, 32'hFFFF_FFFF);
    send_word(dicr_pkg::OP_APPEND, 32'd0);
    send_word(dicr_pkg::OP_APPEND, 32'd0);
    send_word(dicr_pkg::OP_APPEND, 32'd0);
    send_word(dicr_pkg::OP_TRANSLATE, 32'd1);
    send_word(dicr_pkg::OP_TRANSLATE, 32'd0);
    send_word(dicr_pkg::OP_APPEND, 32'd2);
    send_word(dicr_pkg::OP_TRANSLATE, 32'd2);
    send_word(dicr_pkg::OP_CLEAR, 32'd0);

    repeat (12) small_round();

    // Fill the table to its limit, probing it along the way.
    send_word(dicr_pkg::OP_CLEAR, $urandom);
    last = $urandom_range(0, 1 << 16);
    for (int i = 0; i < MAX_IDS; i++) begin
      if (i == 200) steady = 1'b1;
      if (i == 520) steady = 1'b0;
      if (i == 700) hold_req = 1'b1;
      if (i % 16 == 7) send_word(dicr_pkg::OP_TRANSLATE, probe_id());
      last = next_append(last, 1 << 22);
      send_word(dicr_pkg::OP_APPEND, last);
    end
    send_word(dicr_pkg::OP_APPEND, last);
    send_word(dicr_pkg::OP_APPEND, 32'd0);
    send_word(dicr_pkg::OP_APPEND, 32'hFFFF_FFFF);
    for (int i = 0; i < 60; i++) begin
      if ($urandom_range(0, 14) == 0) send_word(OP_UNUSED, $urandom);
      else send_word(dicr_pkg::OP_TRANSLATE, probe_id());
    end
    send_word(dicr_pkg::OP_TRANSLATE, 32'd0);
    send_word(dicr_pkg::OP_TRANSLATE, 32'hFFFF_FFFF);
    send_word(dicr_pkg::OP_CLEAR, $urandom);

    repeat (4) small_round();
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/dicr_pkg.sv
rtl/dicr_ram.sv
rtl/deleted_id_compaction_remap.sv
tb/sv/tb_top.sv
